// File: rtl/differential_drive_odometry_assert.svh
// Assertion macros shared by the odometry RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ddo_pkg.sv
// Shared constants, types and tables for the differential-drive odometry block.
// No dependencies; imported by the interfaces and every module.
package ddo_pkg;

    localparam int COUNT_W     = 32;
    localparam int POS_W       = 32;
    localparam int ANGLE_W     = 16;
    localparam int SCALE_W     = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = 64;
    localparam int DIST_W      = 48;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_RUN   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = $clog2(TABLE_LEN);
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT_SCALE   = 3'd0,
        REG_RIGHT_SCALE  = 3'd1,
        REG_HEADING_GAIN = 3'd2,
        REG_INIT_X       = 3'd3,
        REG_INIT_Y       = 3'd4,
        REG_INIT_HEADING = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic        en;
        logic [31:0] a;
        logic        a_signed;
        logic [31:0] b;
        logic        b_signed;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] angle;
    } t_rot_req;

    typedef struct packed {
        logic        done;
        logic [31:0] sin_q16;
        logic [31:0] cos_q16;
    } t_rot_rsp;

    // Arctangent of 2^-i, full turn = 2^32.
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/ddo_if.sv
// Valid/ready channel interfaces: encoder counts in, pose out, register writes.
// Depends on ddo_pkg for field widths.
interface ddo_in_if import ddo_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;

    modport source (output valid, left_count, right_count, input ready);
    modport sink   (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic        [ANGLE_W-1:0] heading;

    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/ddo_mul.sv
// Shared 33x33 signed multiplier with a registered 64-bit product.
// Depends on ddo_pkg for the request struct.
module ddo_mul import ddo_pkg::*; (
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic signed [32:0] a_ext;
    logic signed [32:0] b_ext;
    logic signed [65:0] prod;
    logic [PROD_W-1:0]  r_prod;

    always_comb begin
        a_ext = $signed({i_req.a_signed & i_req.a[31], i_req.a});
        b_ext = $signed({i_req.b_signed & i_req.b[31], i_req.b});
        prod  = a_ext * b_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= prod[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/ddo_cordic.sv
// Iterative CORDIC: sine and cosine of a 16-bit binary angle, one rotation per cycle.
// Depends on ddo_pkg for the arctangent table, gain and step count.
module ddo_cordic import ddo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rot_req i_req,
    output t_rot_rsp o_rsp
);

    typedef enum logic [1:0] {C_IDLE, C_ROT, C_FOLD} t_state;

    t_state            r_state, n_state;
    logic [31:0]       r_x, n_x;
    logic [31:0]       r_y, n_y;
    logic [31:0]       r_z, n_z;
    logic [1:0]        r_q, n_q;
    logic [STEP_W-1:0] r_i, n_i;
    logic              r_done, n_done;
    logic [31:0]       r_sin, n_sin;
    logic [31:0]       r_cos, n_cos;

    logic [ANGLE_W-1:0] qsum;
    logic [1:0]         q0;
    logic [ANGLE_W-1:0] z0;
    logic [31:0]        xs, ys, atan_i;
    logic [31:0]        c_pre, s_pre, c_rnd, s_rnd;

    always_comb begin
        qsum   = i_req.angle + 16'h2000;
        q0     = qsum[15:14];
        z0     = i_req.angle - {q0, 14'b0};
        xs     = 32'($signed(r_x) >>> r_i);
        ys     = 32'($signed(r_y) >>> r_i);
        atan_i = atan_turn(r_i);

        // Undo the quadrant fold.
        case (r_q)
            2'd0:    begin c_pre = r_x;         s_pre = r_y;         end
            2'd1:    begin c_pre = 32'd0 - r_y; s_pre = r_x;         end
            2'd2:    begin c_pre = 32'd0 - r_x; s_pre = 32'd0 - r_y; end
            default: begin c_pre = r_y;         s_pre = 32'd0 - r_x; end
        endcase
        // Round Q2.30 to Q16.
        c_rnd = 32'($signed(c_pre + 32'd8192) >>> 14);
        s_rnd = 32'($signed(s_pre + 32'd8192) >>> 14);

        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_q     = r_q;
        n_i     = r_i;
        n_done  = 1'b0;
        n_sin   = r_sin;
        n_cos   = r_cos;

        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_x     = CORDIC_GAIN;
                    n_y     = 32'd0;
                    n_z     = {z0, 16'h0};
                    n_q     = q0;
                    n_i     = '0;
                    n_state = C_ROT;
                end
            end
            C_ROT: begin
                if (!r_z[31]) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_i;
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_i;
                end
                n_i = r_i + 1'b1;
                if (r_i == STEP_W'(CORDIC_RUN - 1)) begin
                    n_state = C_FOLD;
                end
            end
            C_FOLD: begin
                n_sin   = s_rnd;
                n_cos   = c_rnd;
                n_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_q   <= n_q;
        r_i   <= n_i;
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.sin_q16 = r_sin;
    assign o_rsp.cos_q16 = r_cos;

endmodule

// File: rtl/differential_drive_odometry.sv
// Differential-drive odometry: each beat of absolute left/right encoder counts yields one
// pose beat (x, y in signed Q16.16 metres, heading in 1/65536 turn). The block takes one
// item at a time, taking a new one only after the last pose is in the output register;
// each item makes eight issue/take passes through the one shared multiplier plus the
// iterative CORDIC rotations. A finished pose waits in the output register; registers
// are written through the config channel, and writing an initial pose register also
// loads the running pose. Uses ddo_pkg, ddo_if, ddo_mul, ddo_cordic and the assertion
// macro header.
module differential_drive_odometry import ddo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ddo_in_if.sink    i_in,
    ddo_out_if.source o_out,
    ddo_cfg_if.sink   i_cfg
);

`include "differential_drive_odometry_assert.svh"

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_TAKE, S_ROT, S_DONE} t_state;
    typedef enum logic [2:0] {
        OP_DL, OP_DR, OP_TURN_LO, OP_TURN_HI, OP_X_LO, OP_X_HI, OP_Y_LO, OP_Y_HI
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [SCALE_W-1:0]  r_left_scale, r_right_scale, r_heading_gain;
    logic [COUNT_W-1:0]  r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic [COUNT_W-1:0]  r_dlt_l, n_dlt_l, r_dlt_r, n_dlt_r;
    logic [DIST_W-1:0]   r_dl, n_dl, r_diff, n_diff, r_travel, n_travel;
    logic [ANGLE_W-1:0]  r_turn, n_turn;
    logic [POS_W-1:0]    r_part, n_part;
    logic [POS_W-1:0]    r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [ANGLE_W-1:0]  r_acc_heading, n_acc_heading;
    logic                r_rot_start, n_rot_start;
    logic                r_out_valid, n_out_valid;
    logic [POS_W-1:0]    r_out_x, n_out_x, r_out_y, n_out_y;
    logic [ANGLE_W-1:0]  r_out_h, n_out_h;

    t_mul_req          mul_req;
    logic [PROD_W-1:0] prod;
    t_rot_req          rot_req;
    t_rot_rsp          rot_rsp;
    logic [DIST_W:0]   sum_lr;
    logic [DIST_W-1:0] prod_dist;
    logic              in_fire, cfg_fire, out_load;

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rot_req),
        .o_rsp   (rot_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign rot_req.start = r_rot_start;
    assign rot_req.angle = r_acc_heading;

    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = $signed(r_out_x);
    assign o_out.pos_y   = $signed(r_out_y);
    assign o_out.heading = r_out_h;

    // Operand select for the shared multiplier.
    always_comb begin
        mul_req.en = (r_state == S_ISSUE);
        case (r_op)
            OP_DL: begin
                mul_req.a = r_dlt_l;        mul_req.a_signed = 1'b1;
                mul_req.b = r_left_scale;   mul_req.b_signed = 1'b0;
            end
            OP_DR: begin
                mul_req.a = r_dlt_r;        mul_req.a_signed = 1'b1;
                mul_req.b = r_right_scale;  mul_req.b_signed = 1'b0;
            end
            OP_TURN_LO: begin
                mul_req.a = r_diff[31:0];   mul_req.a_signed = 1'b0;
                mul_req.b = r_heading_gain; mul_req.b_signed = 1'b0;
            end
            OP_TURN_HI: begin
                mul_req.a = {16'h0, r_diff[DIST_W-1:32]}; mul_req.a_signed = 1'b0;
                mul_req.b = r_heading_gain;               mul_req.b_signed = 1'b0;
            end
            OP_X_LO: begin
                mul_req.a = r_travel[31:0];   mul_req.a_signed = 1'b0;
                mul_req.b = rot_rsp.sin_q16;  mul_req.b_signed = 1'b1;
            end
            OP_X_HI: begin
                mul_req.a = {{16{r_travel[DIST_W-1]}}, r_travel[DIST_W-1:32]};
                mul_req.a_signed = 1'b1;
                mul_req.b = rot_rsp.sin_q16;  mul_req.b_signed = 1'b1;
            end
            OP_Y_LO: begin
                mul_req.a = r_travel[31:0];   mul_req.a_signed = 1'b0;
                mul_req.b = rot_rsp.cos_q16;  mul_req.b_signed = 1'b1;
            end
            default: begin
                mul_req.a = {{16{r_travel[DIST_W-1]}}, r_travel[DIST_W-1:32]};
                mul_req.a_signed = 1'b1;
                mul_req.b = rot_rsp.cos_q16;  mul_req.b_signed = 1'b1;
            end
        endcase
    end

    always_comb begin
        prod_dist = prod[PROD_W-1:16];
        sum_lr    = {r_dl[DIST_W-1], r_dl} + {prod_dist[DIST_W-1], prod_dist};

        n_state       = r_state;
        n_op          = r_op;
        n_prev_l      = r_prev_l;
        n_prev_r      = r_prev_r;
        n_dlt_l       = r_dlt_l;
        n_dlt_r       = r_dlt_r;
        n_dl          = r_dl;
        n_diff        = r_diff;
        n_travel      = r_travel;
        n_turn        = r_turn;
        n_part        = r_part;
        n_acc_x       = r_acc_x;
        n_acc_y       = r_acc_y;
        n_acc_heading = r_acc_heading;
        n_rot_start   = 1'b0;
        n_out_valid   = r_out_valid;
        n_out_x       = r_out_x;
        n_out_y       = r_out_y;
        n_out_h       = r_out_h;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_dlt_l  = i_in.left_count - r_prev_l;
                    n_dlt_r  = i_in.right_count - r_prev_r;
                    n_prev_l = i_in.left_count;
                    n_prev_r = i_in.right_count;
                    n_op     = OP_DL;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: n_state = S_TAKE;
            S_TAKE: begin
                n_state = S_ISSUE;
                n_op    = t_op'(r_op + 3'd1);
                case (r_op)
                    OP_DL: n_dl = prod_dist;
                    OP_DR: begin
                        n_travel = sum_lr[DIST_W:1];
                        n_diff   = prod_dist - r_dl;
                    end
                    OP_TURN_LO: n_turn = prod[47:32];
                    OP_TURN_HI: begin
                        n_acc_heading = r_acc_heading + r_turn + prod[15:0];
                        n_rot_start   = 1'b1;
                        n_state       = S_ROT;
                    end
                    OP_X_LO: n_part = prod[47:16];
                    OP_X_HI: n_acc_x = r_acc_x - r_part - {prod[15:0], 16'h0};
                    OP_Y_LO: n_part = prod[47:16];
                    default: begin
                        n_acc_y = r_acc_y - r_part - {prod[15:0], 16'h0};
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ROT: begin
                if (rot_rsp.done) begin
                    n_op    = OP_X_LO;
                    n_state = S_ISSUE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_acc_x;
                    n_out_y     = r_acc_y;
                    n_out_h     = r_acc_heading;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_op           <= OP_DL;
            r_rot_start    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_left_scale   <= 32'd65536;
            r_right_scale  <= 32'd65536;
            r_heading_gain <= 32'd65536;
            r_prev_l       <= '0;
            r_prev_r       <= '0;
            r_acc_x        <= '0;
            r_acc_y        <= '0;
            r_acc_heading  <= '0;
        end else begin
            r_state       <= n_state;
            r_op          <= n_op;
            r_rot_start   <= n_rot_start;
            r_out_valid   <= n_out_valid;
            r_prev_l      <= n_prev_l;
            r_prev_r      <= n_prev_r;
            r_acc_x       <= n_acc_x;
            r_acc_y       <= n_acc_y;
            r_acc_heading <= n_acc_heading;
            if (cfg_fire) begin
                case (i_cfg.addr)
                    REG_LEFT_SCALE:   r_left_scale   <= i_cfg.data;
                    REG_RIGHT_SCALE:  r_right_scale  <= i_cfg.data;
                    REG_HEADING_GAIN: r_heading_gain <= i_cfg.data;
                    REG_INIT_X:       r_acc_x        <= i_cfg.data;
                    REG_INIT_Y:       r_acc_y        <= i_cfg.data;
                    REG_INIT_HEADING: r_acc_heading  <= i_cfg.data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
        end
        r_dlt_l  <= n_dlt_l;
        r_dlt_r  <= n_dlt_r;
        r_dl     <= n_dl;
        r_diff   <= n_diff;
        r_travel <= n_travel;
        r_turn   <= n_turn;
        r_part   <= n_part;
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_out_h  <= n_out_h;
    end

    `DDO_ASSERT_NEXT(a_busy_after_accept, in_fire, !i_in.ready, "ready after accepting a beat")
    `DDO_ASSERT_SAME(a_rot_done_waited, rot_rsp.done, r_state == S_ROT, "stray CORDIC done")
    `DDO_ASSERT_NEXT(a_out_load, out_load, o_out.valid && (o_out.heading == $past(r_acc_heading)), "output beat lost its heading")
    `DDO_ASSERT_NEXT(a_init_heading, cfg_fire && (i_cfg.addr == REG_INIT_HEADING), r_acc_heading == $past(i_cfg.data[ANGLE_W-1:0]), "initial heading not loaded")

endmodule
